// ===== rtl/lsbbr_pkg.sv =====
// lsbbr_pkg: shared types, constants and codes for the lsb-first bit reader
// used by lsbbr_cursor, lsbbr_store and lsb_first_bit_reader_core
// no dependencies
package lsbbr_pkg;

	localparam int STORE_DEPTH   = 4096;
	localparam int ADDR_W        = 12;
	localparam int LEN_W         = 13;
	localparam int AMT_W         = 16;
	localparam int POS_W         = LEN_W + 3;
	localparam int MAX_READ_BITS = 64;
	localparam int GATHER_BYTES  = MAX_READ_BITS / 8 + 1;
	localparam int CNT_W         = 4;
	localparam int RD_AMT_W      = 7;

	// operation codes
	localparam logic [2:0] OP_LOAD       = 3'd0;
	localparam logic [2:0] OP_READ       = 3'd1;
	localparam logic [2:0] OP_SKIP_BITS  = 3'd2;
	localparam logic [2:0] OP_SKIP_BYTES = 3'd3;
	localparam logic [2:0] OP_SEEK       = 3'd4;
	localparam logic [2:0] OP_ALIGN      = 3'd5;

	// seek origins
	localparam logic [1:0] DIR_START = 2'd0;
	localparam logic [1:0] DIR_CUR   = 2'd1;
	localparam logic [1:0] DIR_END   = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EXHAUSTED = 3'd1;
	localparam logic [2:0] ST_TOO_FEW   = 3'd2;
	localparam logic [2:0] ST_TOO_MANY  = 3'd3;
	localparam logic [2:0] ST_BAD_SEEK  = 3'd4;

	// cursor state
	typedef struct packed {
		logic [LEN_W-1:0] cur_byte;
		logic [2:0]       cur_bit;
		logic             exh;
	} cursor_t;

endpackage

// ===== rtl/lsbbr_store.sv =====
// lsbbr_store: byte store, one write port and one registered read port
// depends on lsbbr_pkg
module lsbbr_store
	import lsbbr_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [STORE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/lsbbr_cursor.sv =====
// lsbbr_cursor: next cursor state and status for one operation
// depends on lsbbr_pkg
module lsbbr_cursor
	import lsbbr_pkg::*;
(
	input  logic [2:0]       op,
	input  logic [AMT_W-1:0] amount,
	input  logic [1:0]       direction,
	input  logic [LEN_W-1:0] len,
	input  cursor_t          cur,
	output cursor_t          nxt,
	output logic [2:0]       status,
	output logic             gather
);

	logic [POS_W-1:0] total;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] left;
	logic [POS_W:0]   bits_sum;
	logic             bits_end;
	logic [AMT_W:0]   bytes_sum;
	logic             bytes_end;
	cursor_t          exh_cur;

	// remaining bits and the two advance forms
	always_comb begin
		total     = {len, 3'b000};
		pos       = {cur.cur_byte, cur.cur_bit};
		if (cur.exh || total <= pos) begin
			left = '0;
		end else begin
			left = total - pos;
		end
		bits_sum  = {1'b0, pos} + (POS_W+1)'(amount);
		bits_end  = ({1'b0, left} < ({1'b0, amount} + 17'd1));
		bytes_sum = (AMT_W+1)'(cur.cur_byte) + {1'b0, amount};
		bytes_end = (bytes_sum > (AMT_W+1)'(len));
		exh_cur   = '{cur_byte: len, cur_bit: 3'd0, exh: 1'b1};
	end

	// operation select
	always_comb begin
		nxt    = cur;
		status = ST_OK;
		gather = 1'b0;
		case (op)
			OP_READ: begin
				if (cur.exh) begin
					status = ST_EXHAUSTED;
				end else if (amount > left) begin
					status = ST_TOO_FEW;
				end else if (amount > AMT_W'(MAX_READ_BITS)) begin
					status = ST_TOO_MANY;
				end else if (amount != '0) begin
					gather = 1'b1;
					if (bits_end) begin
						nxt = exh_cur;
					end else begin
						nxt.cur_byte = bits_sum[POS_W-1:3];
						nxt.cur_bit  = bits_sum[2:0];
					end
				end
			end
			OP_SKIP_BITS: begin
				if (bits_end) begin
					nxt = exh_cur;
				end else begin
					nxt.cur_byte = bits_sum[POS_W-1:3];
					nxt.cur_bit  = bits_sum[2:0];
				end
			end
			OP_SKIP_BYTES: begin
				if (!cur.exh) begin
					if (bytes_end) begin
						nxt = exh_cur;
					end else begin
						nxt.cur_byte = bytes_sum[LEN_W-1:0];
					end
				end
			end
			OP_SEEK: begin
				case (direction)
					DIR_START: begin
						if (amount > AMT_W'(len)) begin
							nxt = exh_cur;
						end else begin
							nxt = '{cur_byte: amount[LEN_W-1:0], cur_bit: 3'd0, exh: 1'b0};
						end
					end
					DIR_CUR: begin
						if (!cur.exh) begin
							if (bytes_end) begin
								nxt = exh_cur;
							end else begin
								nxt.cur_byte = bytes_sum[LEN_W-1:0];
							end
						end
					end
					DIR_END: begin
						if (amount >= AMT_W'(len)) begin
							nxt = '{cur_byte: '0, cur_bit: 3'd0, exh: 1'b0};
						end else begin
							nxt = '{cur_byte: len - amount[LEN_W-1:0], cur_bit: 3'd7,
								exh: 1'b0};
						end
					end
					default: begin
						status = ST_BAD_SEEK;
					end
				endcase
			end
			OP_ALIGN: begin
				if (cur.cur_bit != 3'd0) begin
					nxt.cur_bit = 3'd0;
					if (cur.cur_byte < len) begin
						nxt.cur_byte = cur.cur_byte + 13'd1;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== rtl/lsb_first_bit_reader_core.sv =====
// lsb_first_bit_reader_core: a cursor op's result is registered at the accept edge
// a read of 1..64 bits fetches nine bytes through the single store read port, one a cycle:
// its result is registered as the ninth byte leaves the store, and no item is taken meanwhile
// a new item is taken while the previous result waits, if the output register drains
// arst_n clears cursor, exhausted flag, length and handshake state; store contents undefined
// depends on lsbbr_pkg, lsbbr_cursor, lsbbr_store
module lsb_first_bit_reader_core
	import lsbbr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [12:0]      cfg_wr_data,   // used_length
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,       // amount, direction, load_address, load_data, pad
	input  logic [2:0]       s_tuser,       // op
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [87:0]      m_tdata        // read_value, status, at_end, byte_offset,
	                                        // bit_offset, pad
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_GATHER = 1'b1;

	logic [LEN_W-1:0]  used_length_q;
	logic [LEN_W-1:0]  len;
	cursor_t           cur_q;
	cursor_t           nxt;
	logic [2:0]        status;
	logic              gather;
	logic              state_q;
	logic              accept;

	logic [AMT_W-1:0]  amount;
	logic [1:0]        direction;
	logic [ADDR_W-1:0] load_address;
	logic [7:0]        load_data;

	logic [ADDR_W-1:0] base_q;
	logic [2:0]        sh_q;
	logic [RD_AMT_W-1:0] amt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cap_q;
	logic              rdv_s1;
	logic [63:0]       acc_q;
	logic              issue;
	logic [7:0]        rd_data;
	logic              finish;
	logic [71:0]       full;
	logic [63:0]       mask;
	logic [63:0]       value;

	logic              out_valid_q;
	logic [87:0]       out_data_q;

	// input field unpacking
	assign amount       = s_tdata[15:0];
	assign direction    = s_tdata[17:16];
	assign load_address = s_tdata[29:18];
	assign load_data    = s_tdata[37:30];

	assign len    = (used_length_q > LEN_W'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : used_length_q;
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// next cursor state
	lsbbr_cursor u_cursor (
		.op        (s_tuser),
		.amount    (amount),
		.direction (direction),
		.len       (len),
		.cur       (cur_q),
		.nxt       (nxt),
		.status    (status),
		.gather    (gather)
	);

	// byte store; load addresses always fall inside the store
	assign issue = (state_q == ST_GATHER) && (cnt_q < CNT_W'(GATHER_BYTES));

	lsbbr_store u_store (
		.clk     (clk),
		.wr_en   (accept && (s_tuser == OP_LOAD)),
		.wr_addr (load_address),
		.wr_data (load_data),
		.rd_en   (issue),
		.rd_addr (base_q + ADDR_W'(cnt_q)),
		.rd_data (rd_data)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_length_q <= '0;
		end else if (cfg_wr_en) begin
			used_length_q <= cfg_wr_data;
		end
	end

	// cursor state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cap_q   <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			rdv_s1 <= issue;
			if (accept) begin
				cur_q <= nxt;
				if (gather) begin
					state_q <= ST_GATHER;
					cnt_q   <= '0;
					cap_q   <= '0;
				end
			end else if (state_q == ST_GATHER) begin
				if (issue) begin
					cnt_q <= cnt_q + 4'd1;
				end
				if (finish) begin
					state_q <= ST_IDLE;
				end else if (rdv_s1) begin
					cap_q <= cap_q + 4'd1;
				end
			end
		end
	end

	// read parameters captured at the accept edge; fetched bytes shifted into the accumulator
	always_ff @(posedge clk) begin
		if (accept && gather) begin
			base_q <= cur_q.cur_byte[ADDR_W-1:0];
			sh_q   <= cur_q.cur_bit;
			amt_q  <= amount[RD_AMT_W-1:0];
		end
		if (rdv_s1) begin
			acc_q <= {rd_data, acc_q[63:8]};
		end
	end

	// bit extraction from the nine fetched bytes
	assign finish = (state_q == ST_GATHER) && rdv_s1 && (cap_q == CNT_W'(GATHER_BYTES - 1));
	assign full   = {rd_data, acc_q};
	assign mask   = (amt_q == RD_AMT_W'(MAX_READ_BITS)) ? '1 :
		((64'd1 << amt_q[5:0]) - 64'd1);
	assign value  = full[63+sh_q -: 64] & mask;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !gather) || finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !gather) begin
			out_data_q <= {4'b0, nxt.cur_bit, nxt.cur_byte, nxt.exh, status, 64'd0};
		end else if (finish) begin
			out_data_q <= {4'b0, cur_q.cur_bit, cur_q.cur_byte, cur_q.exh, ST_OK, value};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTH
	// no transfer is taken while bytes are being fetched
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GATHER) |-> !s_tready)
		else $error("input taken during byte fetch");

	// an exhausted reader sits on a byte boundary
	a_exh_bit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.exh |-> (cur_q.cur_bit == 3'd0))
		else $error("exhausted with non-zero bit position");

	// fetch completion never overwrites a pending result
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> !out_valid_q)
		else $error("read result would overwrite pending result");

	// capture count stays within the fetch window
	a_cap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q < CNT_W'(GATHER_BYTES)) && (cnt_q <= CNT_W'(GATHER_BYTES)))
		else $error("fetch counter out of range");
`endif

endmodule

// ===== test/lsb_first_bit_reader_core_tb.sv =====
// lsb_first_bit_reader_core_tb: self-checking bench for the lsb-first bit reader core
// drives stream transfers with random idling and predicts every result in the bench itself
// depends on lsbbr_pkg and lsb_first_bit_reader_core
module lsb_first_bit_reader_core_tb;
	import lsbbr_pkg::*;

	// codes the package leaves unnamed
	localparam logic [2:0] OP_UNUSED_A = 3'd6;
	localparam logic [2:0] OP_UNUSED_B = 3'd7;
	localparam logic [1:0] DIR_BAD     = 2'd3;

	localparam int SETTLE_CYCLES  = 16;
	localparam int RX_HOLD_CYCLES = 240;
	localparam int QUIET_LIMIT    = 3000;
	localparam int REPORT_CAP     = 200;
	localparam int TOP_WINDOW     = 16;

	typedef struct packed {
		logic [63:0] value;
		logic [2:0]  status;
		logic        at_end;
		logic [12:0] byte_pos;
		logic [2:0]  bit_pos;
	} rdr_result_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [12:0] cfg_wr_data = '0;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata     = '0;
	logic [2:0]  s_tuser     = '0;
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [87:0] m_tdata;

	lsb_first_bit_reader_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted reader state
	logic [7:0]  store_img [0:STORE_DEPTH-1];
	bit          loaded    [0:STORE_DEPTH-1];
	int unsigned len_reg;
	int unsigned pos_byte;
	int unsigned pos_bit;
	bit          spent;

	rdr_result_t expected_results [$];

	bit          calm;
	bit          rx_hold_req;
	int          errors;
	int          items_sent;
	int          results_seen;
	int          reads_done;
	int          length_writes;

	function automatic int unsigned active_len();
		return (len_reg < STORE_DEPTH) ? len_reg : STORE_DEPTH;
	endfunction

	function automatic int unsigned bits_remaining();
		int unsigned total;
		int unsigned pos;
		if (spent)
			return 0;
		total = active_len() * 8;
		pos = pos_byte * 8 + pos_bit;
		return (total > pos) ? total - pos : 0;
	endfunction

	function automatic void mark_spent();
		spent = 1'b1;
		pos_byte = active_len();
		pos_bit = 0;
	endfunction

	// bit advance, running off the end leaves the reader spent
	function automatic void advance_by_bits(int unsigned amt);
		if (bits_remaining() < amt + 1) begin
			mark_spent();
		end else begin
			pos_byte += amt / 8;
			pos_bit += amt % 8;
			if (pos_bit > 7) begin
				pos_bit -= 8;
				pos_byte++;
			end
		end
	endfunction

	function automatic void advance_by_bytes(int unsigned amt);
		if (spent)
			return;
		if (pos_byte + amt > active_len())
			mark_spent();
		else
			pos_byte += amt;
	endfunction

	// lsb-first gather, never past the active length
	function automatic logic [63:0] gather_bits(int unsigned amt);
		logic [63:0] v;
		int unsigned start;
		int unsigned q;
		int unsigned b;
		v = '0;
		start = pos_byte * 8 + pos_bit;
		for (int unsigned i = 0; i < amt && i < 64; i++) begin
			q = start + i;
			b = q >> 3;
			if (b < active_len())
				v[i] = store_img[b][q & 7];
		end
		return v;
	endfunction

	function automatic rdr_result_t predict_result(input logic [2:0] op,
			input logic [15:0] amount, input logic [1:0] dir,
			input logic [11:0] addr, input logic [7:0] data);
		rdr_result_t r;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_LOAD: begin
				store_img[addr] = data;
			end
			OP_READ: begin
				if (spent)
					r.status = ST_EXHAUSTED;
				else if (amount > bits_remaining())
					r.status = ST_TOO_FEW;
				else if (amount > MAX_READ_BITS)
					r.status = ST_TOO_MANY;
				else if (amount != 0) begin
					r.value = gather_bits(amount);
					advance_by_bits(amount);
					reads_done++;
				end
			end
			OP_SKIP_BITS: begin
				advance_by_bits(amount);
			end
			OP_SKIP_BYTES: begin
				advance_by_bytes(amount);
			end
			OP_SEEK: begin
				case (dir)
					DIR_START: begin
						spent = 1'b0;
						pos_byte = 0;
						pos_bit = 0;
						advance_by_bytes(amount);
					end
					DIR_CUR: begin
						advance_by_bytes(amount);
					end
					DIR_END: begin
						spent = 1'b0;
						if (amount >= active_len()) begin
							pos_byte = 0;
							pos_bit = 0;
						end else begin
							pos_byte = active_len() - amount;
							pos_bit = 7;
						end
					end
					default: begin
						r.status = ST_BAD_SEEK;
					end
				endcase
			end
			OP_ALIGN: begin
				if (pos_bit > 0) begin
					pos_bit = 0;
					if (pos_byte < active_len())
						pos_byte++;
				end
			end
			default: begin
			end
		endcase
		r.at_end = spent;
		r.byte_pos = 13'(pos_byte);
		r.bit_pos = 3'(pos_bit);
		return r;
	endfunction

	// one item onto the slave side, valid left high for a following transfer
	task automatic send_item(input logic [2:0] op, input logic [15:0] amount,
			input logic [1:0] dir, input logic [11:0] addr, input logic [7:0] data);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, data, addr, dir, amount};
		do
			@(posedge clk);
		while (!s_tready);
		expected_results.insert(expected_results.size(),
			predict_result(op, amount, dir, addr, data));
		if (op == OP_LOAD)
			loaded[addr] = 1'b1;
		items_sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_wait();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// fill the store entries in a window that are not yet loaded
	task automatic load_window(input int unsigned lo, input int unsigned hi);
		for (int unsigned a = lo; a < hi; a++) begin
			if (!loaded[a])
				send_item(OP_LOAD, 16'($urandom_range(0, 32768)), 2'($urandom),
					12'(a), 8'($urandom));
		end
	endtask

	// fill store entries that a read at this length might touch
	task automatic load_up_to(input int unsigned n);
		int unsigned lim;
		lim = (n < STORE_DEPTH) ? n : STORE_DEPTH;
		load_window(0, lim);
	endtask

	// length register written only with the block idle
	task automatic write_length(input int unsigned n);
		drain_wait();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= 13'(n);
		@(posedge clk);
		len_reg = n & 13'h1fff;
		length_writes++;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_length(input int unsigned n);
		load_up_to(n + GATHER_BYTES);
		write_length(n);
	endtask

	task automatic send_op(input logic [2:0] op, input int unsigned amount,
			input logic [1:0] dir);
		send_item(op, 16'(amount), dir, 12'($urandom), 8'($urandom));
	endtask

	// mostly well-formed cursor traffic, some noise
	task automatic send_random_item();
		int unsigned pick;
		int unsigned sub;
		int unsigned n;
		n = active_len();
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 19);
		if (spent && pick < 30) begin
			send_op(OP_SEEK, $urandom_range(0, n / 2 + 1),
				(sub < 10) ? DIR_START : DIR_END);
		end else if (pick < 40) begin
			if (sub < 15)
				send_op(OP_READ, $urandom_range(0, 64), DIR_BAD);
			else if (sub < 17)
				send_op(OP_READ, $urandom_range(65, 300), 2'($urandom));
			else if (sub == 17)
				send_op(OP_READ, $urandom_range(0, 32768), 2'($urandom));
			else
				send_op(OP_READ, bits_remaining() & 16'hffff, 2'($urandom));
		end else if (pick < 52) begin
			if (sub < 16)
				send_op(OP_SKIP_BITS, $urandom_range(0, 24), 2'($urandom));
			else
				send_op(OP_SKIP_BITS, $urandom_range(0, n * 8 + 8), 2'($urandom));
		end else if (pick < 62) begin
			if (sub < 16)
				send_op(OP_SKIP_BYTES, $urandom_range(0, 4), 2'($urandom));
			else
				send_op(OP_SKIP_BYTES, $urandom_range(0, n + 2), 2'($urandom));
		end else if (pick < 77) begin
			if (sub < 6)
				send_op(OP_SEEK, $urandom_range(0, n + 2), DIR_START);
			else if (sub < 12)
				send_op(OP_SEEK, $urandom_range(0, 6), DIR_CUR);
			else if (sub < 19)
				send_op(OP_SEEK, $urandom_range(0, n + 2), DIR_END);
			else
				send_op(OP_SEEK, $urandom_range(0, 32768), DIR_BAD);
		end else if (pick < 85) begin
			send_op(OP_ALIGN, $urandom_range(0, 32768), 2'($urandom));
		end else if (pick < 95) begin
			send_item(OP_LOAD, 16'($urandom_range(0, 32768)), 2'($urandom),
				12'($urandom), 8'($urandom));
		end else begin
			send_op((sub < 10) ? OP_UNUSED_A : OP_UNUSED_B,
				$urandom_range(0, 32768), 2'($urandom));
		end
	endtask

	task automatic send_random_run(input int count);
		repeat (count) send_random_item();
	endtask

	// every operation and each corner at a short length
	task automatic test_directed();
		set_length(16);
		send_op(OP_READ, 0, DIR_START);
		send_op(OP_READ, 65, DIR_START);
		send_op(OP_READ, 64, DIR_START);
		send_op(OP_SEEK, 0, DIR_START);
		send_op(OP_SKIP_BITS, 3, DIR_START);
		send_op(OP_READ, 64, DIR_START);
		send_op(OP_READ, 62, DIR_START);
		send_op(OP_READ, 61, DIR_START);
		send_op(OP_READ, 1, DIR_START);
		send_op(OP_SKIP_BYTES, 2, DIR_START);
		send_op(OP_READ, 32768, DIR_START);
		send_op(OP_SEEK, 3, DIR_END);
		send_op(OP_ALIGN, 0, DIR_START);
		send_op(OP_ALIGN, 0, DIR_START);
		send_op(OP_SEEK, 1, DIR_BAD);
		send_op(OP_SEEK, 1, DIR_CUR);
		send_op(OP_SKIP_BYTES, 2, DIR_START);
		send_op(OP_SEEK, 16, DIR_END);
		send_op(OP_SKIP_BITS, 1, DIR_START);
		send_op(OP_ALIGN, 0, DIR_START);
		send_op(OP_SEEK, 32768, DIR_START);
		send_op(OP_SEEK, 5, DIR_START);
		send_op(OP_READ, 32768, DIR_START);
		send_op(OP_SKIP_BITS, 32768, DIR_START);
		send_op(OP_UNUSED_A, 0, DIR_START);
		send_op(OP_UNUSED_B, 16'hffff & 32768, DIR_BAD);
		send_item(OP_LOAD, 16'd0, DIR_START, 12'hfff, 8'hff);
	endtask

	// extreme lengths; at the top of the store only the last bytes are filled
	// and the cursor is kept near the end
	task automatic test_length_edges();
		set_length(0);
		send_op(OP_READ, 0, DIR_START);
		send_op(OP_READ, 1, DIR_START);
		send_op(OP_SKIP_BITS, 0, DIR_START);
		send_random_run(37);
		set_length(1);
		send_random_run(40);
		load_window(STORE_DEPTH - TOP_WINDOW, STORE_DEPTH);
		write_length(4095);
		send_op(OP_SEEK, 1, DIR_END);
		send_op(OP_READ, 1, DIR_START);
		send_op(OP_READ, 1, DIR_START);
		send_op(OP_SEEK, 9, DIR_END);
		send_op(OP_READ, 64, DIR_START);
		send_op(OP_READ, 2, DIR_START);
		send_op(OP_SEEK, 2, DIR_END);
		send_op(OP_SKIP_BITS, 3, DIR_START);
		send_op(OP_ALIGN, 0, DIR_START);
		send_op(OP_SKIP_BYTES, 1, DIR_START);
		send_op(OP_SEEK, 0, DIR_CUR);
		send_op(OP_SEEK, 4095, DIR_START);
		send_op(OP_SKIP_BITS, 0, DIR_START);
		write_length(4096);
		send_op(OP_SEEK, 9, DIR_END);
		send_op(OP_READ, 64, DIR_START);
		send_op(OP_READ, 1, DIR_START);
		send_op(OP_SEEK, 4096, DIR_END);
		send_op(OP_SEEK, 4096, DIR_START);
		send_op(OP_READ, 1, DIR_START);
		send_op(OP_SKIP_BYTES, 1, DIR_START);
	endtask

	// length dropped beneath the cursor leaves nothing to read
	task automatic test_length_lowered();
		set_length(200);
		send_op(OP_SEEK, 150, DIR_START);
		set_length(40);
		send_op(OP_READ, 1, DIR_START);
		send_op(OP_ALIGN, 0, DIR_START);
		send_op(OP_SKIP_BITS, 0, DIR_START);
		send_random_run(27);
	endtask

	// receiver holds off while items keep coming
	task automatic test_backpressure();
		set_length($urandom_range(32, 96));
		rx_hold_req = 1'b1;
		send_random_run(40);
	endtask

	// sender stops until the pipeline is empty, then resumes
	task automatic test_drain_pause();
		send_random_run(20);
		drain_wait();
		send_random_run(20);
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 10; ph++) begin
			calm = (ph % 4 == 3);
			if ($urandom_range(0, 4) == 0)
				set_length($urandom_range(65, 300));
			else
				set_length($urandom_range(2, 64));
			send_random_run(80);
		end
		calm = 1'b0;
	endtask

	// closing stretch with no idling on either side
	task automatic test_steady_tail();
		calm = 1'b1;
		set_length($urandom_range(8, 64));
		send_random_run(100);
		drain_wait();
	endtask

	// receiver pacing
	initial begin : rx_pace
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic note_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		errors++;
		if (errors <= REPORT_CAP)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		else if (errors == REPORT_CAP + 1)
			$display("%0t: further mismatches not shown", $time);
	endtask

	// result check against the oldest prediction
	always @(posedge clk) begin : result_check
		rdr_result_t got;
		rdr_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.value = m_tdata[63:0];
			got.status = m_tdata[66:64];
			got.at_end = m_tdata[67];
			got.byte_pos = m_tdata[80:68];
			got.bit_pos = m_tdata[83:81];
			results_seen++;
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected result", '0, m_tdata[63:0]);
			end else begin
				want = expected_results.pop_front();
				if (got.value !== want.value)
					note_mismatch("read_value", want.value, got.value);
				if (got.status !== want.status)
					note_mismatch("status", want.status, got.status);
				if (got.at_end !== want.at_end)
					note_mismatch("at_end", want.at_end, got.at_end);
				if (got.byte_pos !== want.byte_pos)
					note_mismatch("byte_offset", want.byte_pos, got.byte_pos);
				if (got.bit_pos !== want.bit_pos)
					note_mismatch("bit_offset", want.bit_pos, got.bit_pos);
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles, %0d results outstanding",
			$time, quiet, expected_results.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin : run
		for (int a = 0; a < STORE_DEPTH; a++) begin
			store_img[a] = '0;
			loaded[a] = 1'b0;
		end
		len_reg = 0;
		pos_byte = 0;
		pos_bit = 0;
		spent = 1'b0;
		calm = 1'b0;
		rx_hold_req = 1'b0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		reads_done = 0;
		length_writes = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_length_edges();
		test_length_lowered();
		test_backpressure();
		test_drain_pause();
		test_random();
		test_steady_tail();

		$display("covered %0d items and %0d results, %0d successful reads, %0d length writes",
			items_sent, results_seen, reads_done, length_writes);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors,
				expected_results.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lsbbr_pkg.sv
rtl/lsbbr_store.sv
rtl/lsbbr_cursor.sv
rtl/lsb_first_bit_reader_core.sv
test/lsb_first_bit_reader_core_tb.sv
